// ===== rtl/exp_adsr_envelope_scale_assert.svh =====
// Assertion macros shared by the envelope pipeline modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef EXP_ADSR_ENVELOPE_SCALE_ASSERT_SVH
`define EXP_ADSR_ENVELOPE_SCALE_ASSERT_SVH

// Condition implies property in the same cycle.
`define EAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition implies a consequence in the next cycle.
`define EAS_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== rtl/eas_pkg.sv =====
// Types and constants for the exponential envelope pipeline.
// Used by eas_front, eas_div, eas_exp and exp_adsr_envelope_scale.
`default_nettype none
package eas_pkg;

  localparam int NumVoices = 64;
  localparam int VOICE_W   = 6;
  localparam int TIME_W    = 32;
  localparam int ELAP_W    = TIME_W + 1;
  localparam int DUR_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int NUM_W     = 18;
  localparam int DIVD_W    = NUM_W + 2 + 16;
  localparam int REM_W     = DUR_W;
  localparam int Q_W       = DIVD_W - REM_W;
  localparam int S_W       = Q_W + 6;
  localparam int S2_W      = 22;
  localparam int S3_W      = 18;
  localparam int S4_W      = 14;
  localparam int D6_W      = 16;
  localparam int D24_W     = 10;
  localparam int T_W       = 31;
  localparam int SQUARES   = 8;
  localparam int EXP_STAGES = 5 + SQUARES;
  localparam int K6        = S3_W + 3;
  localparam int K24       = S4_W + 5;

  localparam logic [GAIN_W-1:0] UNITY    = 16'h8000;
  localparam logic [T_W-1:0]    ONE_Q30  = 31'h4000_0000;
  localparam logic [K6-2:0]     M6       = (K6-1)'(((2 ** K6) + 5) / 6);
  localparam logic [K24-4:0]    M24      = (K24-3)'(((2 ** K24) + 23) / 24);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ATTACK,
    PH_DECAY,
    PH_RELEASE
  } phase_t;

  typedef struct packed {
    logic [DUR_W-1:0]   release_ms;
    logic [GAIN_W-1:0]  sustain_level;
    logic [DUR_W-1:0]   decay_ms;
    logic [DUR_W-1:0]   attack_ms;
    logic [TIME_W-1:0]  off_time;
    logic               off_valid;
    logic [TIME_W-1:0]  on_time;
    logic               on_valid;
    logic [TIME_W-1:0]  now_ms;
    logic [VOICE_W-1:0] voice;
  } item_t;

  typedef struct packed {
    logic [VOICE_W-1:0] voice;
    logic [GAIN_W-1:0]  base;
    logic [GAIN_W-1:0]  coef;
    logic               sub;
    logic               done;
    logic               zero;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/eas_front.sv =====
// Front end: elapsed time, phase selection and divider operands, three stages.
// Depends on eas_pkg.
`default_nettype none
`include "exp_adsr_envelope_scale_assert.svh"
module eas_front import eas_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  item_t             in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIVD_W-1:0] out_dividend,
  output logic [DUR_W-1:0]  out_den,
  output side_t             out_side
);

  logic [2:0] v;
  logic [2:0] en;

  logic [ELAP_W-1:0]  el1;
  phase_t             ph1;
  logic [DUR_W-1:0]   a1, d1, r1;
  logic [GAIN_W-1:0]  s1;
  logic [VOICE_W-1:0] voice1;

  logic [ELAP_W-1:0]  num2;
  logic [DUR_W-1:0]   den2;
  phase_t             ph2;
  logic [GAIN_W-1:0]  s2;
  logic               done2;
  logic [VOICE_W-1:0] voice2;

  logic [DIVD_W-1:0] divd3;
  logic [DUR_W-1:0]  den3;
  side_t             side3;

  logic [TIME_W-1:0] start;
  logic [ELAP_W-1:0] el_next;
  phase_t            ph1_next;
  logic [ELAP_W-1:0] num_next;
  logic [DUR_W-1:0]  den_next;
  phase_t            ph2_next;
  logic              done_next;
  logic              big;
  logic [NUM_W+1:0]  num3x;
  side_t             side_next;

  always_comb begin
    en[2] = !v[2] || out_ready;
    en[1] = !v[1] || en[2];
    en[0] = !v[0] || en[1];
    in_ready = en[0];
  end

  always_comb begin
    start = in_item.on_valid ? in_item.on_time : in_item.off_time;
    if (in_item.now_ms < start) begin
      el_next = ELAP_W'(1);
    end else begin
      el_next = {1'b0, in_item.now_ms} - {1'b0, start} + ELAP_W'(1);
    end
    if (in_item.on_valid) begin
      ph1_next = PH_ATTACK;
    end else if (in_item.off_valid) begin
      ph1_next = PH_RELEASE;
    end else begin
      ph1_next = PH_IDLE;
    end
  end

  always_comb begin
    num_next  = el1;
    den_next  = '0;
    ph2_next  = ph1;
    done_next = 1'b0;
    case (ph1)
      PH_ATTACK: begin
        if (el1 > ELAP_W'(a1)) begin
          ph2_next = PH_DECAY;
          num_next = el1 - ELAP_W'(a1);
          den_next = d1;
        end else begin
          den_next = a1;
        end
      end
      PH_RELEASE: begin
        den_next  = r1;
        done_next = el1 > ELAP_W'(r1);
      end
      default: begin
        num_next = '0;
      end
    endcase
  end

  always_comb begin
    big   = num2 > ELAP_W'({den2, 2'b00});
    num3x = (NUM_W+2)'(num2[NUM_W-1:0]) * (NUM_W+2)'(3);
    side_next.voice = voice2;
    side_next.done  = done2;
    side_next.zero  = (den2 == '0) || big || (ph2 == PH_IDLE);
    case (ph2)
      PH_ATTACK: begin
        side_next.base = UNITY;
        side_next.coef = UNITY;
        side_next.sub  = 1'b1;
      end
      PH_DECAY: begin
        side_next.base = s2;
        if (s2 <= UNITY) begin
          side_next.coef = UNITY - s2;
          side_next.sub  = 1'b0;
        end else begin
          side_next.coef = s2 - UNITY;
          side_next.sub  = 1'b1;
        end
      end
      PH_RELEASE: begin
        side_next.base = '0;
        side_next.coef = s2;
        side_next.sub  = 1'b0;
      end
      default: begin
        side_next.base = UNITY;
        side_next.coef = '0;
        side_next.sub  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      el1    <= el_next;
      ph1    <= ph1_next;
      a1     <= in_item.attack_ms;
      d1     <= in_item.decay_ms;
      r1     <= in_item.release_ms;
      s1     <= in_item.sustain_level;
      voice1 <= in_item.voice;
    end
    if (en[1]) begin
      num2   <= num_next;
      den2   <= den_next;
      ph2    <= ph2_next;
      s2     <= s1;
      done2  <= done_next;
      voice2 <= voice1;
    end
    if (en[2]) begin
      divd3 <= {num3x, 16'h0000};
      den3  <= den2;
      side3 <= side_next;
    end
  end

  assign out_valid    = v[2];
  assign out_dividend = divd3;
  assign out_den      = den3;
  assign out_side     = side3;

  `EAS_ASSERT(a_front_attack_den, v[2] && !side3.zero && side3.sub && side3.base == UNITY && side3.coef == UNITY |-> den3 != '0, "attack word with zero duration")

endmodule
`default_nettype wire

// ===== rtl/eas_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on eas_pkg; side information travels alongside each word.
`default_nettype none
`include "exp_adsr_envelope_scale_assert.svh"
module eas_div import eas_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DIVD_W-1:0] in_dividend,
  input  logic [DUR_W-1:0]  in_den,
  input  side_t             in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [Q_W-1:0]    out_q,
  output side_t             out_side
);

  logic             v   [Q_W];
  logic [Q_W-1:0]   en;
  logic [REM_W-1:0] rem [Q_W];
  logic [Q_W-1:0]   wrk [Q_W];
  logic [DUR_W-1:0] dq  [Q_W];
  side_t            sd  [Q_W];

  always_comb begin
    en[Q_W-1] = !v[Q_W-1] || out_ready;
    for (int k = Q_W - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic             src_v;
    logic [REM_W-1:0] src_rem;
    logic [Q_W-1:0]   src_wrk;
    logic [DUR_W-1:0] src_den;
    side_t            src_sd;
    logic [REM_W:0]   trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign src_v   = in_valid;
      assign src_rem = in_dividend[DIVD_W-1 -: REM_W];
      assign src_wrk = in_dividend[Q_W-1:0];
      assign src_den = in_den;
      assign src_sd  = in_side;
    end else begin : g_next
      assign src_v   = v[i-1];
      assign src_rem = rem[i-1];
      assign src_wrk = wrk[i-1];
      assign src_den = dq[i-1];
      assign src_sd  = sd[i-1];
    end

    always_comb begin
      trial = {src_rem, src_wrk[Q_W-1]};
      ge    = trial >= {1'b0, src_den};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en[i]) begin
        v[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        rem[i] <= ge ? REM_W'(trial - {1'b0, src_den}) : trial[REM_W-1:0];
        wrk[i] <= {src_wrk[Q_W-2:0], ge};
        dq[i]  <= src_den;
        sd[i]  <= src_sd;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[Q_W-1];
  assign out_q     = wrk[Q_W-1];
  assign out_side  = sd[Q_W-1];

  `EAS_ASSERT(a_div_rem, v[Q_W-1] && !sd[Q_W-1].zero |-> rem[Q_W-1] < dq[Q_W-1], "divider remainder not below divisor")

endmodule
`default_nettype wire

// ===== rtl/eas_exp.sv =====
// Pipelined exp(-x) in Q30: a fourth-order series on x/256, then eight squarings.
// Depends on eas_pkg; at most two multipliers per stage, side information carried along.
`default_nettype none
`include "exp_adsr_envelope_scale_assert.svh"
module eas_exp import eas_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [Q_W-1:0] in_q,
  input  side_t          in_side,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [T_W-1:0] out_t,
  output side_t          out_side
);

  logic                  v  [EXP_STAGES];
  logic [EXP_STAGES-1:0] en;
  side_t                 sd [EXP_STAGES];

  logic [S_W-1:0]   s_a, s_b, s_c, s_d;
  logic [S2_W-1:0]  s2_a, s2_b, s2_c, s2_d;
  logic [S3_W-1:0]  s3_b;
  logic [S4_W-1:0]  s4_c;
  logic [D6_W-1:0]  d6_c, d6_d;
  logic [D24_W-1:0] d24_d;
  logic [T_W-1:0]   e0;
  logic [T_W-1:0]   sq [SQUARES];

  logic [S_W-1:0]          s_in;
  logic [2*S_W-1:0]        p_a;
  logic [S2_W+S_W-1:0]     p_b;
  logic [S3_W+S_W-1:0]     p_c;
  logic [S3_W+K6-2:0]      p_6;
  logic [S4_W+K24-4:0]     p_24;
  logic [T_W:0]            sum_e;

  always_comb begin
    en[EXP_STAGES-1] = !v[EXP_STAGES-1] || out_ready;
    for (int k = EXP_STAGES - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_comb begin
    s_in  = {in_q, 6'b000000};
    p_a   = s_in * s_in;
    p_b   = s2_a * s_a;
    p_c   = s3_b * s_b;
    p_6   = s3_b * M6;
    p_24  = s4_c * M24;
    sum_e = (T_W+1)'(ONE_Q30) + (T_W+1)'(s2_d >> 1) + (T_W+1)'(d24_d)
          - (T_W+1)'(s_d) - (T_W+1)'(d6_d);
  end

  for (genvar i = 0; i < EXP_STAGES; i++) begin : g_valid
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          v[i] <= 1'b0;
        end else if (en[i]) begin
          v[i] <= in_valid;
        end
      end
      always_ff @(posedge clk) begin
        if (en[i]) sd[i] <= in_side;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          v[i] <= 1'b0;
        end else if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en[i]) sd[i] <= sd[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s_a  <= s_in;
      s2_a <= p_a[2*S_W-1:30];
    end
    if (en[1]) begin
      s_b  <= s_a;
      s2_b <= s2_a;
      s3_b <= p_b[S2_W+S_W-1:30];
    end
    if (en[2]) begin
      s_c  <= s_b;
      s2_c <= s2_b;
      s4_c <= p_c[S3_W+S_W-1:30];
      d6_c <= p_6[K6+D6_W-1:K6];
    end
    if (en[3]) begin
      s_d   <= s_c;
      s2_d  <= s2_c;
      d6_d  <= d6_c;
      d24_d <= p_24[K24+D24_W-1:K24];
    end
    if (en[4]) begin
      e0 <= sum_e[T_W-1:0];
    end
  end

  for (genvar j = 0; j < SQUARES; j++) begin : g_square
    logic [T_W-1:0]   src;
    logic [2*T_W-1:0] prod;

    if (j == 0) begin : g_first
      assign src = e0;
    end else begin : g_next
      assign src = sq[j-1];
    end

    assign prod = src * src + (2*T_W)'(ONE_Q30 >> 1);

    always_ff @(posedge clk) begin
      if (en[5+j]) sq[j] <= prod[2*T_W-2:30];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[EXP_STAGES-1];
  assign out_t     = sq[SQUARES-1];
  assign out_side  = sd[EXP_STAGES-1];

  `EAS_ASSERT(a_exp_range, v[EXP_STAGES-1] && !sd[EXP_STAGES-1].zero |-> sq[SQUARES-1] <= ONE_Q30, "exponential term above one")

endmodule
`default_nettype wire

// ===== rtl/exp_adsr_envelope_scale.sv =====
// Exponential ADSR envelope gain, one word per cycle while the output is not stalled.
// Pipeline: 3 front stages, 20 divider stages, 13 exp stages, 1 scale stage, output register.
// Throughput: one word per cycle; each stage advances when it is empty or its successor moves.
// Reset (rst, synchronous): clears all valid bits; payload registers keep their contents.
// Depends on eas_pkg, eas_front, eas_div and eas_exp.
`default_nettype none
`include "exp_adsr_envelope_scale_assert.svh"
module exp_adsr_envelope_scale import eas_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // voice, now_ms, on_valid, on_time, off_valid, off_time, attack_ms, decay_ms,
  // sustain_level, release_ms
  input  logic [167:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // voice_out, gain, then two zero bits
  output logic [23:0]  m_tdata,
  // release_done
  output logic         m_tuser
);

  logic              fr_valid, fr_ready;
  logic [DIVD_W-1:0] fr_dividend;
  logic [DUR_W-1:0]  fr_den;
  side_t             fr_side;

  logic           dv_valid, dv_ready;
  logic [Q_W-1:0] dv_q;
  side_t          dv_side;

  logic           ex_valid, ex_ready;
  logic [T_W-1:0] ex_t;
  side_t          ex_side;

  logic              vf1;
  logic              en_f1, en_out;
  logic [GAIN_W:0]   prod_f1;
  side_t             side_f1;
  logic [GAIN_W-1:0] coef_eff;
  logic [GAIN_W+T_W-1:0] scaled;
  logic [GAIN_W:0]   gain_next;

  logic [VOICE_W-1:0] voice_out;
  logic [GAIN_W-1:0]  gain;
  logic               release_done;

  eas_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_item      (item_t'(s_tdata)),
    .out_valid    (fr_valid),
    .out_ready    (fr_ready),
    .out_dividend (fr_dividend),
    .out_den      (fr_den),
    .out_side     (fr_side)
  );

  eas_div u_div (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (fr_valid),
    .in_ready    (fr_ready),
    .in_dividend (fr_dividend),
    .in_den      (fr_den),
    .in_side     (fr_side),
    .out_valid   (dv_valid),
    .out_ready   (dv_ready),
    .out_q       (dv_q),
    .out_side    (dv_side)
  );

  eas_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_q      (dv_q),
    .in_side   (dv_side),
    .out_valid (ex_valid),
    .out_ready (ex_ready),
    .out_t     (ex_t),
    .out_side  (ex_side)
  );

  always_comb begin
    en_out   = !m_tvalid || m_tready;
    en_f1    = !vf1 || en_out;
    ex_ready = en_f1;
    coef_eff = ex_side.zero ? '0 : ex_side.coef;
    scaled   = (GAIN_W+T_W)'(coef_eff) * (GAIN_W+T_W)'(ex_t)
             + (GAIN_W+T_W)'(ONE_Q30 >> 1);
    if (side_f1.sub) begin
      gain_next = {1'b0, side_f1.base} - prod_f1;
    end else begin
      gain_next = {1'b0, side_f1.base} + prod_f1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf1      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en_f1)  vf1      <= ex_valid;
      if (en_out) m_tvalid <= vf1;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f1) begin
      prod_f1 <= scaled[GAIN_W+T_W-1:30];
      side_f1 <= ex_side;
    end
    if (en_out) begin
      voice_out    <= side_f1.voice;
      gain         <= gain_next[GAIN_W-1:0];
      release_done <= side_f1.done;
    end
  end

  assign m_tdata = {2'b00, gain, voice_out};
  assign m_tuser = release_done;

  `EAS_ASSERT(a_top_ready, !m_tvalid |-> s_tready, "input stalled while output register is empty")
  `EAS_ASSERT_NEXT(a_top_load, vf1 && !m_tvalid, m_tvalid, "scaled word not moved into empty output register")

endmodule
`default_nettype wire
